// ===== sv/cgq_pkg.sv =====
`timescale 1ns / 1ps
// cgq_pkg: widths, Gauss-Legendre node and weight tables and rounding helper
// for the composite Gauss quadrature block. No dependencies.

package cgq_pkg;

  // divider: 64-bit dividend, 40-bit divisor, 32 quotient bits
  localparam int DVW = 40;
  localparam int QW  = 32;
  localparam int NUMW = 64;
  // shared multiplier operand and product widths
  localparam int MW = 34;
  localparam int PW = 68;
  // interval accumulator width
  localparam int TW = 44;

  localparam logic [DVW-1:0]  D_ONE   = DVW'(64'd1 << 24);
  localparam logic [NUMW-1:0] SQ_HALF = NUMW'(64'd1 << 23);

  localparam logic signed [PW-1:0] RES_MAX = PW'(64'sd2147483647);
  localparam logic signed [PW-1:0] RES_MIN = -PW'(64'sd2147483648);

  // node t in Q1.30, k is the point count minus one
  function automatic logic signed [31:0] node_q30(input logic [1:0] k, input logic [1:0] j);
    logic signed [31:0] t;
    case ({k, j})
      4'b0100: t = 32'sd619925131;
      4'b0101: t = -32'sd619925131;
      4'b1001: t = 32'sd831716841;
      4'b1010: t = -32'sd831716841;
      4'b1100: t = 32'sd365051866;
      4'b1101: t = -32'sd365051866;
      4'b1110: t = 32'sd924638074;
      4'b1111: t = -32'sd924638074;
      default: t = '0;
    endcase
    return t;
  endfunction

  // weight w in Q2.30, unsigned (the one-point weight is 2.0)
  function automatic logic [31:0] weight_q30(input logic [1:0] k, input logic [1:0] j);
    logic [31:0] w;
    case ({k, j})
      4'b0000: w = 32'h8000_0000;
      4'b0100: w = 32'd1073741824;
      4'b0101: w = 32'd1073741824;
      4'b1000: w = 32'd954437177;
      4'b1001: w = 32'd596523236;
      4'b1010: w = 32'd596523236;
      4'b1100: w = 32'd700235528;
      4'b1101: w = 32'd700235528;
      4'b1110: w = 32'd373506296;
      4'b1111: w = 32'd373506296;
      default: w = '0;
    endcase
    return w;
  endfunction

  // v / 2^s rounded to nearest, ties away from zero
  function automatic logic signed [PW-1:0] rnd_sh(input logic signed [PW-1:0] v,
                                                 input int unsigned s);
    logic [PW-1:0] mag;
    logic [PW-1:0] half;
    logic [PW-1:0] r;
    mag  = v[PW-1] ? PW'(-v) : PW'(v);
    half = PW'(1) << (s - 1);
    r    = (mag + half) >> s;
    return v[PW-1] ? -$signed(r) : $signed(r);
  endfunction

endpackage

// ===== sv/composite_gauss_quadrature.sv =====
`timescale 1ns / 1ps
// composite_gauss_quadrature: composite 1- to 4-point Gauss-Legendre integration
// of 2x/(1+x^2) over a Q8.16 range. Depends on cgq_pkg.

// One request at a time. The datapath is a single radix-2 restoring divider that
// delivers one quotient bit per cycle and is shared by the width, interval-center
// and integrand divisions, next to one shared 34x34 multiplier. in_stall is high
// from the accepted transfer until the result is loaded into the output register;
// the next request may be taken while that result still waits on out_stall.
// Results are Q16.16, clipped with a flag.
module composite_gauss_quadrature #(
  parameter int MAX_INTERVALS = 16,
  parameter int MAX_POINTS    = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_lower_bound,
  input  logic signed [23:0] in_upper_bound,
  input  logic [2:0]         in_num_points,
  input  logic [4:0]         in_num_intervals,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_integral,
  output logic               out_saturated
);

  localparam int NW  = $clog2(MAX_INTERVALS + 1);
  localparam int CNW = $clog2(cgq_pkg::QW);

  typedef enum logic [18:0] {
    S_IDLE   = 19'd1 << 0,
    S_HW_DIV = 19'd1 << 1,
    S_HW_SET = 19'd1 << 2,
    S_C_MUL  = 19'd1 << 3,
    S_C_LD   = 19'd1 << 4,
    S_C_DIV  = 19'd1 << 5,
    S_C_SET  = 19'd1 << 6,
    S_N_MUL  = 19'd1 << 7,
    S_N_RND  = 19'd1 << 8,
    S_N_X    = 19'd1 << 9,
    S_SQ     = 19'd1 << 10,
    S_F_LD   = 19'd1 << 11,
    S_F_DIV  = 19'd1 << 12,
    S_W_MUL  = 19'd1 << 13,
    S_W_ACC  = 19'd1 << 14,
    S_I_RND  = 19'd1 << 15,
    S_I_MUL  = 19'd1 << 16,
    S_I_ACC  = 19'd1 << 17,
    S_FIN    = 19'd1 << 18
  } state_t;

  state_t state_r, state_nxt;

  // request registers
  logic signed [31:0]              a_r, a_nxt;
  logic signed [32:0]              span_r, span_nxt;
  logic [NW-1:0]                   n_r, n_nxt;
  logic [NW-1:0]                   i_r, i_nxt;
  logic [1:0]                      kidx_r, kidx_nxt;
  logic [1:0]                      j_r, j_nxt;
  logic signed [32:0]              hw_r, hw_nxt;
  logic signed [33:0]              c_r, c_nxt;
  logic signed [33:0]              rn_r, rn_nxt;
  logic [31:0]                     ux_r, ux_nxt;
  logic                            xneg_r, xneg_nxt;
  logic signed [63:0]              acc_r, acc_nxt;
  logic signed [cgq_pkg::MW-1:0]   racc_r, racc_nxt;
  logic signed [cgq_pkg::TW-1:0]   total_r, total_nxt;
  logic signed [cgq_pkg::PW-1:0]   prod_r, prod_nxt;

  // divider registers
  logic [cgq_pkg::DVW-1:0]         rem_r, rem_nxt;
  logic [cgq_pkg::QW-1:0]          dvd_r, dvd_nxt;
  logic [cgq_pkg::DVW-1:0]         dvs_r, dvs_nxt;
  logic [CNW-1:0]                  cnt_r, cnt_nxt;
  logic                            dneg_r, dneg_nxt;

  // output register
  logic                            out_valid_r, out_valid_nxt;
  logic signed [31:0]              out_integral_r, out_integral_nxt;
  logic                            out_saturated_r, out_saturated_nxt;

  // combinational helpers
  logic signed [31:0]              a_in, b_in;
  logic signed [32:0]              span_in;
  logic [32:0]                     span_mag;
  logic [NW-1:0]                   n_in;
  logic [2:0]                      k_in;
  logic [cgq_pkg::DVW-1:0]         div_t;
  logic                            div_ge;
  logic                            div_last;
  logic signed [32:0]              q_s;
  logic signed [cgq_pkg::MW-1:0]   mul_a, mul_b;
  logic signed [cgq_pkg::PW-1:0]   mul_p;
  logic signed [34:0]              x_s;
  logic [cgq_pkg::DVW-1:0]         d_f;
  logic signed [cgq_pkg::PW-1:0]   res;
  logic                            in_xfer;
  logic                            out_free;

  assign in_stall      = (state_r != S_IDLE);
  assign in_xfer       = in_valid && !in_stall;
  assign out_free      = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_integral  = out_integral_r;
  assign out_saturated = out_saturated_r;

  assign a_in     = {in_lower_bound, 8'h00};
  assign b_in     = {in_upper_bound, 8'h00};
  assign span_in  = 33'(b_in) - 33'(a_in);
  assign span_mag = span_in[32] ? 33'(-span_in) : 33'(span_in);

  always_comb begin
    if (in_num_intervals == '0) begin
      n_in = NW'(1);
    end else if (32'(in_num_intervals) > 32'(MAX_INTERVALS)) begin
      n_in = NW'(MAX_INTERVALS);
    end else begin
      n_in = NW'(in_num_intervals);
    end
    if (in_num_points == '0) begin
      k_in = 3'd1;
    end else if (32'(in_num_points) > 32'(MAX_POINTS)) begin
      k_in = 3'(MAX_POINTS);
    end else begin
      k_in = in_num_points;
    end
  end

  // one restoring step per cycle, quotient shifts into dvd_r
  assign div_t    = {rem_r[cgq_pkg::DVW-2:0], dvd_r[cgq_pkg::QW-1]};
  assign div_ge   = (div_t >= dvs_r);
  assign div_last = (cnt_r == {CNW{1'b1}});
  assign q_s      = dneg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});

  assign x_s = 35'(c_r) + 35'(rn_r);
  assign d_f = cgq_pkg::D_ONE
             + cgq_pkg::DVW'((prod_r[63:0] + cgq_pkg::SQ_HALF) >> 24);
  assign res = cgq_pkg::rnd_sh(cgq_pkg::PW'(total_r), 8);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_C_MUL: begin
        mul_a = cgq_pkg::MW'({i_r, 1'b1});
        mul_b = cgq_pkg::MW'(span_r);
      end
      S_N_MUL: begin
        mul_a = cgq_pkg::MW'(hw_r);
        mul_b = cgq_pkg::MW'(cgq_pkg::node_q30(kidx_r, j_r));
      end
      S_SQ: begin
        mul_a = cgq_pkg::MW'(ux_r);
        mul_b = cgq_pkg::MW'(ux_r);
      end
      S_W_MUL: begin
        mul_a = cgq_pkg::MW'(cgq_pkg::weight_q30(kidx_r, j_r));
        mul_b = cgq_pkg::MW'(q_s);
      end
      S_I_MUL: begin
        mul_a = racc_r;
        mul_b = cgq_pkg::MW'(hw_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = cgq_pkg::PW'(mul_a) * cgq_pkg::PW'(mul_b);

  always_comb begin
    state_nxt         = state_r;
    a_nxt             = a_r;
    span_nxt          = span_r;
    n_nxt             = n_r;
    i_nxt             = i_r;
    kidx_nxt          = kidx_r;
    j_nxt             = j_r;
    hw_nxt            = hw_r;
    c_nxt             = c_r;
    rn_nxt            = rn_r;
    ux_nxt            = ux_r;
    xneg_nxt          = xneg_r;
    acc_nxt           = acc_r;
    racc_nxt          = racc_r;
    total_nxt         = total_r;
    prod_nxt          = prod_r;
    rem_nxt           = rem_r;
    dvd_nxt           = dvd_r;
    dvs_nxt           = dvs_r;
    cnt_nxt           = cnt_r;
    dneg_nxt          = dneg_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_integral_nxt  = out_integral_r;
    out_saturated_nxt = out_saturated_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          a_nxt     = a_in;
          span_nxt  = span_in;
          n_nxt     = n_in;
          kidx_nxt  = 2'(k_in - 3'd1);
          i_nxt     = '0;
          total_nxt = '0;
          // half width: |span| / 2n
          rem_nxt   = '0;
          dvd_nxt   = cgq_pkg::QW'(span_mag);
          dvs_nxt   = cgq_pkg::DVW'({n_in, 1'b0});
          cnt_nxt   = '0;
          dneg_nxt  = span_in[32];
          state_nxt = S_HW_DIV;
        end
      end
      S_HW_DIV, S_C_DIV, S_F_DIV: begin
        rem_nxt = div_ge ? div_t - dvs_r : div_t;
        dvd_nxt = {dvd_r[cgq_pkg::QW-2:0], div_ge};
        cnt_nxt = cnt_r + CNW'(1);
        if (div_last) begin
          case (state_r)
            S_HW_DIV: state_nxt = S_HW_SET;
            S_C_DIV:  state_nxt = S_C_SET;
            default:  state_nxt = S_W_MUL;
          endcase
        end
      end
      S_HW_SET: begin
        hw_nxt    = q_s;
        state_nxt = S_C_MUL;
      end
      S_C_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_C_LD;
      end
      S_C_LD: begin
        // center offset: |(2i+1)*span| / 2n
        begin
          logic [cgq_pkg::PW-1:0] pm;
          logic [cgq_pkg::NUMW-1:0] num;
          pm  = prod_r[cgq_pkg::PW-1] ? cgq_pkg::PW'(-prod_r) : cgq_pkg::PW'(prod_r);
          num = pm[cgq_pkg::NUMW-1:0];
          rem_nxt = cgq_pkg::DVW'(num[cgq_pkg::NUMW-1:cgq_pkg::QW]);
          dvd_nxt = num[cgq_pkg::QW-1:0];
        end
        dvs_nxt   = cgq_pkg::DVW'({n_r, 1'b0});
        cnt_nxt   = '0;
        dneg_nxt  = prod_r[cgq_pkg::PW-1];
        acc_nxt   = '0;
        j_nxt     = '0;
        state_nxt = S_C_DIV;
      end
      S_C_SET: begin
        c_nxt     = 34'(a_r) + 34'(q_s);
        state_nxt = S_N_MUL;
      end
      S_N_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_N_RND;
      end
      S_N_RND: begin
        rn_nxt    = 34'(cgq_pkg::rnd_sh(prod_r, 30));
        state_nxt = S_N_X;
      end
      S_N_X: begin
        xneg_nxt  = x_s[34];
        ux_nxt    = x_s[34] ? 32'(-x_s) : 32'(x_s);
        state_nxt = S_SQ;
      end
      S_SQ: begin
        prod_nxt  = mul_p;
        state_nxt = S_F_LD;
      end
      S_F_LD: begin
        // q = (2|x| * 2^30 + d/2) / d
        begin
          logic [cgq_pkg::NUMW-1:0] num;
          num = cgq_pkg::NUMW'({ux_r, 31'b0}) + cgq_pkg::NUMW'(d_f >> 1);
          rem_nxt = cgq_pkg::DVW'(num[cgq_pkg::NUMW-1:cgq_pkg::QW]);
          dvd_nxt = num[cgq_pkg::QW-1:0];
        end
        dvs_nxt   = d_f;
        cnt_nxt   = '0;
        dneg_nxt  = xneg_r;
        state_nxt = S_F_DIV;
      end
      S_W_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_W_ACC;
      end
      S_W_ACC: begin
        acc_nxt = acc_r + 64'(prod_r);
        if (j_r == kidx_r) begin
          state_nxt = S_I_RND;
        end else begin
          j_nxt     = j_r + 2'd1;
          state_nxt = S_N_MUL;
        end
      end
      S_I_RND: begin
        racc_nxt  = cgq_pkg::MW'(cgq_pkg::rnd_sh(cgq_pkg::PW'(acc_r), 30));
        state_nxt = S_I_MUL;
      end
      S_I_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_I_ACC;
      end
      S_I_ACC: begin
        total_nxt = total_r + cgq_pkg::TW'(cgq_pkg::rnd_sh(prod_r, 30));
        if ((NW + 1)'(i_r) + (NW + 1)'(1) == (NW + 1)'(n_r)) begin
          state_nxt = S_FIN;
        end else begin
          i_nxt     = i_r + NW'(1);
          state_nxt = S_C_MUL;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (res > cgq_pkg::RES_MAX) begin
            out_integral_nxt  = 32'h7FFF_FFFF;
            out_saturated_nxt = 1'b1;
          end else if (res < cgq_pkg::RES_MIN) begin
            out_integral_nxt  = 32'h8000_0000;
            out_saturated_nxt = 1'b1;
          end else begin
            out_integral_nxt  = 32'(res);
            out_saturated_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r             <= a_nxt;
    span_r          <= span_nxt;
    n_r             <= n_nxt;
    i_r             <= i_nxt;
    kidx_r          <= kidx_nxt;
    j_r             <= j_nxt;
    hw_r            <= hw_nxt;
    c_r             <= c_nxt;
    rn_r            <= rn_nxt;
    ux_r            <= ux_nxt;
    xneg_r          <= xneg_nxt;
    acc_r           <= acc_nxt;
    racc_r          <= racc_nxt;
    total_r         <= total_nxt;
    prod_r          <= prod_nxt;
    rem_r           <= rem_nxt;
    dvd_r           <= dvd_nxt;
    dvs_r           <= dvs_nxt;
    cnt_r           <= cnt_nxt;
    dneg_r          <= dneg_nxt;
    out_integral_r  <= out_integral_nxt;
    out_saturated_r <= out_saturated_nxt;
  end

endmodule

// ===== sv/cgq_checker.sv =====
`timescale 1ns / 1ps
// cgq_checker: port-level assertions for composite_gauss_quadrature,
// attached to the top level by the bind below. No package dependency.

module cgq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_integral,
  input logic               out_saturated
);

  // one request in flight: an accepted transfer closes the input side
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted a second request while busy");

  // no result shows up the cycle after acceptance
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after acceptance");

  // clipped results sit at the rails
  a_sat_rails: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_integral == 32'sh7FFF_FFFF || out_integral == 32'sh8000_0000)
    else $error("saturation flag without a clipped value");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_integral) && $stable(out_saturated))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind composite_gauss_quadrature cgq_checker u_cgq_checker (.*);

// ===== bench/tb_composite_gauss_quadrature.sv =====
`timescale 1ns / 1ps
// tb_composite_gauss_quadrature: self-checking bench for composite_gauss_quadrature.
// Drives directed and random integration requests, predicts each Q16.16 result
// in plain 64-bit arithmetic and checks it in order. Depends only on the RTL.

module tb_composite_gauss_quadrature;

  typedef struct {
    logic signed [31:0] value;
    logic               clipped;
  } integral_t;

  class quad_scoreboard;
    integral_t pending_integrals[$];
    int        errors = 0;

    // v / 2^s to nearest, ties away from zero
    function longint round_shift(longint v, int s);
      longint unsigned mag;
      mag = (v < 0) ? longint'(-v) : v;
      mag = (mag + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // Q1.30 nodes and Q2.30 weights, kk is the point count
    function longint gl_node(int kk, int j);
      case ({kk[2:0], j[1:0]})
        {3'd2, 2'd0}: return 64'sd619925131;
        {3'd2, 2'd1}: return -64'sd619925131;
        {3'd3, 2'd1}: return 64'sd831716841;
        {3'd3, 2'd2}: return -64'sd831716841;
        {3'd4, 2'd0}: return 64'sd365051866;
        {3'd4, 2'd1}: return -64'sd365051866;
        {3'd4, 2'd2}: return 64'sd924638074;
        {3'd4, 2'd3}: return -64'sd924638074;
        default:      return 64'sd0;
      endcase
    endfunction

    function longint gl_weight(int kk, int j);
      case ({kk[2:0], j[1:0]})
        {3'd1, 2'd0}: return 64'sd2147483648;
        {3'd2, 2'd0}: return 64'sd1073741824;
        {3'd2, 2'd1}: return 64'sd1073741824;
        {3'd3, 2'd0}: return 64'sd954437177;
        {3'd3, 2'd1}: return 64'sd596523236;
        {3'd3, 2'd2}: return 64'sd596523236;
        {3'd4, 2'd0}: return 64'sd700235528;
        {3'd4, 2'd1}: return 64'sd700235528;
        {3'd4, 2'd2}: return 64'sd373506296;
        {3'd4, 2'd3}: return 64'sd373506296;
        default:      return 64'sd0;
      endcase
    endfunction

    // 2x/(1+x^2): x in Q.24, result in Q.30
    function longint integrand(longint x);
      longint unsigned ux, sq, d, num, q;
      ux  = (x < 0) ? longint'(-x) : x;
      sq  = ux * ux;
      d   = (64'd1 << 24) + ((sq + (64'd1 << 23)) >> 24);
      num = (2 * ux) << 30;
      q   = (num + d / 2) / d;
      return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    function integral_t predict_integral(logic signed [23:0] lo, logic signed [23:0] up,
                                         logic [2:0] k, logic [4:0] n);
      longint    a, b, span, hw, c, acc, total, res, x;
      int        kk, nn;
      integral_t r;
      kk = (k == 0) ? 1 : ((k > 4) ? 4 : int'(k));
      nn = (n == 0) ? 1 : ((n > 16) ? 16 : int'(n));
      a = longint'(lo) * 256;
      b = longint'(up) * 256;
      span = b - a;
      hw = span / longint'(2 * nn);
      total = 0;
      for (int i = 0; i < nn; i++) begin
        c = a + (longint'(2 * i + 1) * span) / longint'(2 * nn);
        acc = 0;
        for (int j = 0; j < kk; j++) begin
          x = c + round_shift(hw * gl_node(kk, j), 30);
          acc += gl_weight(kk, j) * integrand(x);
        end
        total += round_shift(round_shift(acc, 30) * hw, 30);
      end
      res = round_shift(total, 8);
      r.clipped = 1'b0;
      if (res > 64'sd2147483647) begin
        res = 64'sd2147483647;
        r.clipped = 1'b1;
      end else if (res < -64'sd2147483648) begin
        res = -64'sd2147483648;
        r.clipped = 1'b1;
      end
      r.value = res[31:0];
      return r;
    endfunction

    function void note_request(logic signed [23:0] lo, logic signed [23:0] up,
                               logic [2:0] k, logic [4:0] n);
      pending_integrals.push_back(predict_integral(lo, up, k, n));
    endfunction

    function void check_result(logic signed [31:0] got, logic got_clipped);
      integral_t e;
      if (pending_integrals.size() == 0) begin
        $display("%0t: unexpected result integral=%0d saturated=%0b",
                 $time, got, got_clipped);
        errors++;
        return;
      end
      e = pending_integrals.pop_front();
      if (got !== e.value || got_clipped !== e.clipped) begin
        $display("%0t: expected integral=%0d saturated=%0b, got integral=%0d saturated=%0b",
                 $time, e.value, e.clipped, got, got_clipped);
        errors++;
      end
    endfunction

    function int pending();
      return pending_integrals.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [23:0] in_lower_bound = '0;
  logic signed [23:0] in_upper_bound = '0;
  logic [2:0]         in_num_points = '0;
  logic [4:0]         in_num_intervals = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_integral;
  logic               out_saturated;

  quad_scoreboard sb;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;

  composite_gauss_quadrature dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_lower_bound   (in_lower_bound),
    .in_upper_bound   (in_upper_bound),
    .in_num_points    (in_num_points),
    .in_num_intervals (in_num_intervals),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_integral     (out_integral),
    .out_saturated    (out_saturated)
  );

  always #5 clk = ~clk;

  // result side: check every transfer, then pick the next stall value
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_integral, out_saturated);
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 2500;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rx_idle_on ? ($urandom_range(99) < 25) : 1'b0;
    end
  end

  task automatic send_request(input logic signed [23:0] lo, input logic signed [23:0] up,
                              input logic [2:0] k, input logic [4:0] n);
    while (tx_idle_on && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_lower_bound <= lo;
    in_upper_bound <= up;
    in_num_points <= k;
    in_num_intervals <= n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(lo, up, k, n);
  endtask

  function automatic logic signed [23:0] rand_bound();
    if ($urandom_range(1))
      return 24'($urandom);
    // otherwise a short range around zero, within +-4.0
    return 24'(int'($urandom_range(0, 524288)) - 262144);
  endfunction

  task automatic send_random(input int count, input bit short_only);
    logic [2:0] k;
    logic [4:0] n;
    for (int i = 0; i < count; i++) begin
      k = 3'($urandom_range(0, 7));
      // large interval counts are slow, keep them rare
      if (!short_only && $urandom_range(99) < 15)
        n = 5'($urandom_range(0, 31));
      else
        n = 5'($urandom_range(0, 4));
      send_request(rand_bound(), rand_bound(), k, n);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 0..1 with every point count
    for (int p = 1; p <= 4; p++)
      send_request(24'sh000000, 24'sh010000, 3'(p), 5'd1);
    // out-of-range and zero counts are clamped
    send_request(24'sh000000, 24'sh020000, 3'd0, 5'd0);
    send_request(-24'sh018000, 24'sh030000, 3'd5, 5'd2);
    send_request(-24'sh018000, 24'sh030000, 3'd6, 5'd3);
    send_request(24'sh008000, 24'sh050000, 3'd7, 5'd17);
    send_request(-24'sh050000, 24'sh008000, 3'd2, 5'd31);
    // reversed and empty ranges
    send_request(24'sh010000, 24'sh000000, 3'd3, 5'd3);
    send_request(24'sh123456, 24'sh123456, 3'd4, 5'd16);
    send_request(-24'sh800000, -24'sh800000, 3'd1, 5'd1);
    // extremes of the bounds
    send_request(-24'sh800000, 24'sh7fffff, 3'd4, 5'd16);
    send_request(24'sh7fffff, -24'sh800000, 3'd2, 5'd31);
    send_request(-24'sh800000, -24'sh7fffff, 3'd3, 5'd1);
    send_request(24'sh7ffffe, 24'sh7fffff, 3'd4, 5'd2);
    send_request(-24'sh030000, 24'sh020000, 3'd3, 5'd5);
    send_request(24'shffffff, 24'sh000001, 3'd1, 5'd8);

    send_random(80, 1'b0);

    // sender pauses until every result is back
    wait_drained();

    // receiver holds off while requests keep coming, so the input stalls
    hold_req <= 1'b1;
    send_random(8, 1'b1);

    // stretch with no idling on either side
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_random(60, 1'b0);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    send_random(80, 1'b0);

    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
